### rtl/core/fsv_pkg.sv
// Shared types, constants and helpers for the float sample value validator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fsv_pkg;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_SIGN    = 4'd1,
    PH_INT     = 4'd2,
    PH_FRAC    = 4'd3,
    PH_LEADPT  = 4'd4,
    PH_EXP     = 4'd5,
    PH_EXPSIGN = 4'd6,
    PH_EXPDIG  = 4'd7,
    PH_WORD    = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       saw_sign;
    logic [1:0] word_position;
    logic [1:0] word_alive;
    logic       rejected;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
    logic       no_char;
  } beat_t;

  localparam int         WORD_LEN  = 3;
  localparam logic [1:0] ALIVE_INF = 2'b01;
  localparam logic [1:0] ALIVE_NAN = 2'b10;
  localparam logic [1:0] ALIVE_ALL = 2'b11;

  localparam scan_state_t SCAN_CLEAR = '{
    phase:         PH_START,
    saw_sign:      1'b0,
    word_position: 2'd0,
    word_alive:    ALIVE_ALL,
    rejected:      1'b0
  };

  function automatic logic [7:0] inf_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = "i";
      2'd1:    c = "n";
      default: c = "f";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] nan_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = "n";
      2'd1:    c = "a";
      default: c = "n";
    endcase
    return c;
  endfunction

endpackage

### rtl/core/fsv_in_stage.sv
// Input register of the validator: captures one character beat per cycle unless stalled.
// Depends on fsv_pkg for the beat type.
`timescale 1ns / 1ps

module fsv_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           src_valid,
  input  fsv_pkg::beat_t src_beat,
  output logic           hold_valid,
  output fsv_pkg::beat_t hold_beat
);
  import fsv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (adv) begin
      hold_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hold_beat <= src_beat;
    end
  end

endmodule

### rtl/core/fsv_scan_step.sv
// Combinational scan step: next scanner state for one beat and the verdict.
// Depends on fsv_pkg for state types and the inf/nan letter tables.
`timescale 1ns / 1ps

module fsv_scan_step (
  input  fsv_pkg::scan_state_t cur,
  input  fsv_pkg::beat_t       beat,
  output fsv_pkg::scan_state_t fed,
  output logic                 verdict
);
  import fsv_pkg::*;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return c inside {"+", "-"};
  endfunction

  function automatic scan_state_t word_feed(input scan_state_t st, input logic [7:0] c);
    scan_state_t r;
    logic [7:0]  lc;
    logic [1:0]  alive;
    r     = st;
    lc    = (c inside {["A":"Z"]}) ? (c | 8'h20) : c;
    alive = st.word_alive;
    if (st.word_position == 2'(WORD_LEN)) begin
      r.rejected = 1'b1;
    end else begin
      if (lc != inf_char(st.word_position)) alive = alive & ALIVE_NAN;
      if (lc != nan_char(st.word_position)) alive = alive & ALIVE_INF;
      r.word_alive = alive;
      if (alive == 2'b00) begin
        r.rejected = 1'b1;
      end else begin
        r.word_position = st.word_position + 2'd1;
      end
    end
    return r;
  endfunction

  function automatic scan_state_t lead_feed(input scan_state_t st, input logic [7:0] c);
    scan_state_t r;
    r = st;
    if (is_digit(c)) begin
      r.phase = PH_INT;
    end else if (c == ".") begin
      r.phase = PH_LEADPT;
    end else begin
      r.phase         = PH_WORD;
      r.word_position = 2'd0;
      r.word_alive    = st.saw_sign ? ALIVE_INF : ALIVE_ALL;
      r               = word_feed(r, c);
    end
    return r;
  endfunction

  function automatic scan_state_t exp_feed(input scan_state_t st, input logic [7:0] c);
    scan_state_t r;
    r = st;
    if (is_digit(c)) r.phase = PH_EXPDIG;
    else             r.rejected = 1'b1;
    return r;
  endfunction

  logic [7:0] c;
  assign c = beat.char_code;

  always_comb begin
    fed = cur;
    if (!beat.no_char && !cur.rejected) begin
      case (cur.phase)
        PH_START: begin
          if (is_sign(c)) begin
            fed.saw_sign = 1'b1;
            fed.phase    = PH_SIGN;
          end else begin
            fed = lead_feed(cur, c);
          end
        end
        PH_SIGN: fed = lead_feed(cur, c);
        PH_INT: begin
          if (c == ".")                       fed.phase    = PH_FRAC;
          else if (c inside {"e", "E"})       fed.phase    = PH_EXP;
          else if (!is_digit(c))              fed.rejected = 1'b1;
        end
        PH_FRAC: begin
          if (c inside {"e", "E"})            fed.phase    = PH_EXP;
          else if (!is_digit(c))              fed.rejected = 1'b1;
        end
        PH_LEADPT: begin
          if (is_digit(c)) fed.phase    = PH_FRAC;
          else             fed.rejected = 1'b1;
        end
        PH_EXP: begin
          if (is_sign(c)) fed.phase = PH_EXPSIGN;
          else            fed       = exp_feed(cur, c);
        end
        PH_EXPSIGN: fed = exp_feed(cur, c);
        PH_EXPDIG: begin
          if (!is_digit(c)) fed.rejected = 1'b1;
        end
        PH_WORD: fed = word_feed(cur, c);
        default: fed.rejected = 1'b1;
      endcase
    end
  end

  always_comb begin
    verdict = 1'b0;
    if (!fed.rejected) begin
      case (fed.phase)
        PH_INT, PH_FRAC, PH_EXPDIG: verdict = 1'b1;
        PH_WORD: verdict = (fed.word_position == 2'(WORD_LEN)) && (fed.word_alive != 2'b00);
        default: verdict = 1'b0;
      endcase
    end
  end

endmodule

### rtl/core/float_sample_value_validator_unit.sv
// Float sample value validator: one character beat accepted per cycle unless stalled.
// A verdict beat is offered from the result register after the beat marked last passes the input register.
// Throughput is one beat per cycle unless stalled, set by the single scan-state register.
// The source is stalled only while a verdict is held and stalled downstream.
// Synchronous reset empties both stages and returns the scanner to string start.
// Depends on fsv_pkg, fsv_in_stage and fsv_scan_step.
`timescale 1ns / 1ps

module float_sample_value_validator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  logic [7:0] char_code,
  input  logic       is_last,
  input  logic       no_char,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       accepted
);
  import fsv_pkg::*;

  logic        adv;
  beat_t       src_beat;
  logic        hold_valid;
  beat_t       hold_beat;
  scan_state_t scan;
  scan_state_t scan_fed;
  logic        verdict;

  assign src_stall = res_valid && res_stall;
  assign adv       = !src_stall;
  assign src_beat  = '{char_code: char_code, is_last: is_last, no_char: no_char};

  fsv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .src_valid  (src_valid),
    .src_beat   (src_beat),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat)
  );

  fsv_scan_step u_step (
    .cur     (scan),
    .beat    (hold_beat),
    .fed     (scan_fed),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan      <= SCAN_CLEAR;
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= hold_valid && hold_beat.is_last;
      if (hold_valid) begin
        scan <= hold_beat.is_last ? SCAN_CLEAR : scan_fed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      accepted <= verdict;
    end
  end

endmodule
